>>> src/pcm_wav_pkg.sv
package pcm_wav_pkg;

   localparam int BYTE_W = 8;
   localparam int ERR_W = 3;
   localparam int CFG_W = 31;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam int HDR_LEN = 44;
   localparam int HDR_AW = $clog2(HDR_LEN);

   localparam logic [HDR_AW-1:0] LAST_IDX = HDR_AW'(HDR_LEN - 1);
   localparam logic [HDR_AW-1:0] OFS_RIFF_SIZE = HDR_AW'(4);
   localparam logic [HDR_AW-1:0] OFS_CHANNELS = HDR_AW'(22);
   localparam logic [HDR_AW-1:0] OFS_RATE_B1 = HDR_AW'(29);
   localparam logic [HDR_AW-1:0] OFS_RATE_B2 = HDR_AW'(30);
   localparam logic [HDR_AW-1:0] OFS_BLOCK_ALIGN = HDR_AW'(32);
   localparam logic [HDR_AW-1:0] OFS_DATA_SIZE = HDR_AW'(40);

   localparam logic [31:0] RIFF_EXTRA = 32'd36;
   localparam logic [31:0] SIZE_LIMIT = 32'hFFFF_FFFF - RIFF_EXTRA;

   localparam logic REG_TRIM = 1'b0;
   localparam logic REG_OUTS = 1'b1;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE   = 3'd0,
      ERR_SHORT  = 3'd1,
      ERR_CANON  = 3'd2,
      ERR_AUDIO  = 3'd3,
      ERR_LIMIT  = 3'd4,
      ERR_LENGTH = 3'd5
   } err_type;

   // fixed header bytes of a canonical 32 kHz pcm16 file
   localparam logic [BYTE_W-1:0] HDR_TMPL [0:HDR_LEN-1] = '{
      8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6D, 8'h74, 8'h20,
      8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h10, 8'h00, 8'h64, 8'h61, 8'h74, 8'h61,
      8'h00, 8'h00, 8'h00, 8'h00
   };
   localparam logic [HDR_LEN-1:0] HDR_FIXED = 44'h0FE9FBFFF0F;

   function automatic logic hdr_byte_ok(input logic [HDR_AW-1:0] idx,
                                        input logic [BYTE_W-1:0] d,
                                        input logic stereo);
      logic ok;
      case (idx)
         OFS_CHANNELS:    ok = (d == 8'h01) || (d == 8'h02);
         OFS_RATE_B1:     ok = (d == (stereo ? 8'hF4 : 8'hFA));
         OFS_RATE_B2:     ok = (d == (stereo ? 8'h01 : 8'h00));
         OFS_BLOCK_ALIGN: ok = (d == (stereo ? 8'h04 : 8'h02));
         default:         ok = !HDR_FIXED[idx] || (d == HDR_TMPL[idx]);
      endcase
      return ok;
   endfunction

endpackage

>>> src/pcm_wav_if.sv
interface pcm_wav_req_if;
   import pcm_wav_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              stream_end;
   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface pcm_wav_rsp_if;
   import pcm_wav_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [ERR_W-1:0]  error_code;
   logic              run_last;
   logic              delivery_last;
   modport source (output valid, output out_byte, output error_code, output run_last,
                   output delivery_last, input ready);
   modport sink (input valid, input out_byte, input error_code, input run_last,
                 input delivery_last, output ready);
endinterface

>>> src/pcm_wav_ram.sv
module pcm_wav_ram #(
   parameter int WIDTH = pcm_wav_pkg::BYTE_W,
   parameter int DEPTH = pcm_wav_pkg::HDR_LEN,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/pcm16_wav_header_check_and_trim.sv
// header bytes: one beat per cycle, while the output is free, to collect the 44-byte header
// after the 44th byte: header scan (read, check per byte), 4 check steps on the shared adder,
// then a read and a write state per header beat out, set by the header ram port; a held output stalls it
// data bytes: one beat per cycle while the output is free, result registered, valid in the cycle after the input beat
// reset (synchronous, active high) clears the sequencer, output valid and both registers;
// the header ram is not cleared
module pcm16_wav_header_check_and_trim (
   input  logic                              clock,
   input  logic                              reset,
   pcm_wav_req_if.sink                       req_ch,
   pcm_wav_rsp_if.source                     rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcm_wav_pkg::CSR_AW-1:0]    paddr,
   input  logic [pcm_wav_pkg::CSR_DW-1:0]    pwdata,
   output logic [pcm_wav_pkg::CSR_DW-1:0]    prdata,
   output logic                              pready
);
   import pcm_wav_pkg::*;

   localparam int UNIT_W = 34;

   typedef enum logic [11:0] {
      ST_HEAD     = 12'b0000_0000_0001,
      ST_SCAN_RD  = 12'b0000_0000_0010,
      ST_SCAN_CK  = 12'b0000_0000_0100,
      ST_CHK_LEN  = 12'b0000_0000_1000,
      ST_CHK_TRIM = 12'b0000_0001_0000,
      ST_CHK_SIZE = 12'b0000_0010_0000,
      ST_MK_RIFF  = 12'b0000_0100_0000,
      ST_EMIT_RD  = 12'b0000_1000_0000,
      ST_EMIT_WR  = 12'b0001_0000_0000,
      ST_ERR      = 12'b0010_0000_0000,
      ST_DATA     = 12'b0100_0000_0000,
      ST_DISCARD  = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [HDR_AW-1:0] cnt_ff, cnt_in;
   logic              ended_ff, ended_in;
   logic              stereo_ff, stereo_in;
   logic              bad_ff, bad_in;
   logic [31:0]       riff_ff, riff_in;
   logic [31:0]       dlen_ff, dlen_in;
   logic [31:0]       skip_left_ff, skip_left_in;
   logic [31:0]       emit_left_ff, emit_left_in;
   logic [32:0]       dcnt_ff, dcnt_in;
   err_type           err_ff, err_in;
   logic [CFG_W-1:0]  trim_ff, outs_ff;

   logic              ovalid_ff, ovalid_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   err_type           oerr_ff, oerr_in;
   logic              orun_ff, orun_in;
   logic              odlast_ff, odlast_in;
   logic              out_load;

   logic              out_free;
   logic              in_rdy;
   logic              acc;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_rdata;

   logic [UNIT_W-1:0] ua, ub, uc, usum;
   logic              u_eq, u_gt;
   logic [CFG_W-1:0]  frames;
   logic [32:0]       out_al, trim_al;
   logic              has_data, has_err, bad_len;
   logic [32:0]       dcnt_next;
   logic              csr_wr;

   // csr
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[CSR_AW-1] == REG_OUTS) ? {1'b0, outs_ff} : {1'b0, trim_ff};

   // handshake
   assign out_free = !ovalid_ff || rsp_ch.ready;
   assign in_rdy = out_free &&
                   (state_ff == ST_HEAD || state_ff == ST_DATA || state_ff == ST_DISCARD);
   assign acc = req_ch.valid && in_rdy;
   assign req_ch.ready = in_rdy;

   assign rsp_ch.valid = ovalid_ff;
   assign rsp_ch.out_byte = obyte_ff;
   assign rsp_ch.error_code = oerr_ff;
   assign rsp_ch.run_last = orun_ff;
   assign rsp_ch.delivery_last = odlast_ff;

   // header store
   assign ram_we = acc && (state_ff == ST_HEAD);

   pcm_wav_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (HDR_LEN)
   ) u_hdr_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff),
      .wdata (req_ch.in_byte),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   // shared add and compare unit
   assign frames = stereo_ff ? {1'b0, dlen_ff[31:2]} : dlen_ff[31:1];
   assign out_al = stereo_ff ? {outs_ff, 2'b00} : {1'b0, outs_ff, 1'b0};
   assign trim_al = stereo_ff ? {trim_ff, 2'b00} : {1'b0, trim_ff, 1'b0};

   always_comb begin
      case (state_ff)
         ST_CHK_LEN: begin
            ua = {2'b00, dlen_ff};
            ub = {2'b00, RIFF_EXTRA};
            uc = {2'b00, riff_ff};
         end
         ST_CHK_TRIM: begin
            ua = {3'b000, trim_ff};
            ub = {3'b000, outs_ff};
            uc = {3'b000, frames};
         end
         ST_CHK_SIZE: begin
            ua = {1'b0, out_al};
            ub = '0;
            uc = {2'b00, SIZE_LIMIT};
         end
         default: begin
            ua = {2'b00, emit_left_ff};
            ub = {2'b00, RIFF_EXTRA};
            uc = '0;
         end
      endcase
   end

   assign usum = ua + ub;
   assign u_eq = (usum == uc);
   assign u_gt = (usum > uc);

   assign bad_len = stereo_ff ? (dlen_ff[1:0] != 2'b00) : dlen_ff[0];
   assign dcnt_next = (dcnt_ff == '1) ? dcnt_ff : dcnt_ff + 33'd1;
   assign has_data = (skip_left_ff == '0) && (emit_left_ff != '0);
   assign has_err = req_ch.stream_end && (dcnt_next != {1'b0, dlen_ff});

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ended_in = ended_ff;
      stereo_in = stereo_ff;
      bad_in = bad_ff;
      riff_in = riff_ff;
      dlen_in = dlen_ff;
      skip_left_in = skip_left_ff;
      emit_left_in = emit_left_ff;
      dcnt_in = dcnt_ff;
      err_in = err_ff;
      out_load = 1'b0;
      obyte_in = '0;
      oerr_in = ERR_NONE;
      orun_in = 1'b1;
      odlast_in = 1'b0;

      case (state_ff)
         ST_HEAD: begin
            if (acc) begin
               if (cnt_ff == LAST_IDX) begin
                  ended_in = req_ch.stream_end;
                  bad_in = 1'b0;
                  cnt_in = '0;
                  state_in = ST_SCAN_RD;
               end else if (req_ch.stream_end) begin
                  out_load = 1'b1;
                  oerr_in = ERR_SHORT;
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CK;
         end
         ST_SCAN_CK: begin
            if (!hdr_byte_ok(cnt_ff, ram_rdata, stereo_ff)) begin
               bad_in = 1'b1;
            end
            if (cnt_ff == OFS_CHANNELS) begin
               stereo_in = (ram_rdata == 8'h02);
            end
            if (cnt_ff[HDR_AW-1:2] == OFS_RIFF_SIZE[HDR_AW-1:2]) begin
               riff_in = {ram_rdata, riff_ff[31:8]};
            end
            if (cnt_ff[HDR_AW-1:2] == OFS_DATA_SIZE[HDR_AW-1:2]) begin
               dlen_in = {ram_rdata, dlen_ff[31:8]};
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_CHK_LEN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_CHK_LEN: begin
            if (bad_ff || !u_eq || bad_len) begin
               err_in = ERR_CANON;
               state_in = ST_ERR;
            end else if (ended_ff && (dlen_ff != '0)) begin
               err_in = ERR_LENGTH;
               state_in = ST_ERR;
            end else begin
               state_in = ST_CHK_TRIM;
            end
         end
         ST_CHK_TRIM: begin
            if (u_gt) begin
               err_in = ERR_AUDIO;
               state_in = ST_ERR;
            end else begin
               state_in = ST_CHK_SIZE;
            end
         end
         ST_CHK_SIZE: begin
            if (u_gt) begin
               err_in = ERR_LIMIT;
               state_in = ST_ERR;
            end else begin
               skip_left_in = trim_al[31:0];
               emit_left_in = out_al[31:0];
               dcnt_in = '0;
               state_in = ST_MK_RIFF;
            end
         end
         ST_MK_RIFF: begin
            riff_in = usum[31:0];
            cnt_in = '0;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               out_load = 1'b1;
               if (cnt_ff[HDR_AW-1:2] == OFS_RIFF_SIZE[HDR_AW-1:2]) begin
                  obyte_in = riff_ff[{cnt_ff[1:0], 3'b000} +: BYTE_W];
               end else if (cnt_ff[HDR_AW-1:2] == OFS_DATA_SIZE[HDR_AW-1:2]) begin
                  obyte_in = emit_left_ff[{cnt_ff[1:0], 3'b000} +: BYTE_W];
               end else begin
                  obyte_in = ram_rdata;
               end
               orun_in = (cnt_ff == LAST_IDX);
               odlast_in = (cnt_ff == LAST_IDX) && (emit_left_ff == '0);
               if (cnt_ff == LAST_IDX) begin
                  cnt_in = '0;
                  state_in = ended_ff ? ST_HEAD : ST_DATA;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_load = 1'b1;
               oerr_in = err_ff;
               cnt_in = '0;
               state_in = ended_ff ? ST_HEAD : ST_DISCARD;
            end
         end
         ST_DATA: begin
            if (acc) begin
               dcnt_in = dcnt_next;
               if (skip_left_ff != '0) begin
                  skip_left_in = skip_left_ff - 32'd1;
               end else if (emit_left_ff != '0) begin
                  emit_left_in = emit_left_ff - 32'd1;
               end
               if (has_data) begin
                  out_load = 1'b1;
                  obyte_in = req_ch.in_byte;
                  orun_in = !has_err;
                  odlast_in = (emit_left_ff == 32'd1);
               end else if (has_err) begin
                  out_load = 1'b1;
                  oerr_in = ERR_LENGTH;
               end
               if (has_data && has_err) begin
                  // data beat first, length error beat after it
                  err_in = ERR_LENGTH;
                  ended_in = 1'b1;
                  state_in = ST_ERR;
               end else if (req_ch.stream_end) begin
                  cnt_in = '0;
                  state_in = ST_HEAD;
               end
            end
         end
         ST_DISCARD: begin
            if (acc && req_ch.stream_end) begin
               cnt_in = '0;
               state_in = ST_HEAD;
            end
         end
         default: begin
            cnt_in = '0;
            state_in = ST_HEAD;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         ovalid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         ovalid_in = 1'b0;
      end else begin
         ovalid_in = ovalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEAD;
         cnt_ff <= '0;
         ovalid_ff <= 1'b0;
         trim_ff <= '0;
         outs_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovalid_ff <= ovalid_in;
         if (csr_wr && (paddr[CSR_AW-1] == REG_TRIM)) begin
            trim_ff <= pwdata[CFG_W-1:0];
         end
         if (csr_wr && (paddr[CSR_AW-1] == REG_OUTS)) begin
            outs_ff <= pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ended_ff <= ended_in;
      stereo_ff <= stereo_in;
      bad_ff <= bad_in;
      riff_ff <= riff_in;
      dlen_ff <= dlen_in;
      skip_left_ff <= skip_left_in;
      emit_left_ff <= emit_left_in;
      dcnt_ff <= dcnt_in;
      err_ff <= err_in;
      if (out_load) begin
         obyte_ff <= obyte_in;
         oerr_ff <= oerr_in;
         orun_ff <= orun_in;
         odlast_ff <= odlast_in;
      end
   end

`ifndef SYNTH
   a_err_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && (oerr_ff != ERR_NONE)) |-> (orun_ff && !odlast_ff && (obyte_ff == '0)))
      else $error("error beat carries data or flags");

   a_ram_write_head_only: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_HEAD))
      else $error("header store written outside header collection");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten while held");

   a_header_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WR && out_load && cnt_ff == LAST_IDX)
         |=> (state_ff == ST_HEAD || state_ff == ST_DATA))
      else $error("header burst did not end in data or head");
`endif

endmodule

>>> tb/pcm16_wav_header_check_and_trim_tb.sv
module pcm16_wav_header_check_and_trim_tb;
   import pcm_wav_pkg::*;

   localparam int HEADER_BYTES = 44;
   localparam logic [31:0] RIFF_OVERHEAD = 32'd36;
   localparam logic [31:0] SAMPLE_HZ = 32'd32000;
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
   localparam logic [15:0] PCM_FORMAT = 16'd1;
   localparam logic [15:0] SAMPLE_BITS = 16'd16;
   localparam longint unsigned POS_LIMIT = 64'h1_FFFF_FFFF;
   localparam int SETTLE_CYCLES = 400;
   localparam int PHASE_BEATS = 30;
   localparam int HOLD_CYCLES = 600;

   typedef enum logic [1:0] {SCAN_HEADER, PASS_DATA, DROP_REST} scan_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      err_type           err;
      logic              run_last;
      logic              delivery_last;
   } wav_out_beat_type;

   class wav_trim_tracker;
      logic [BYTE_W-1:0] hdr [HEADER_BYTES];
      longint unsigned   pos, data_len, skip, emit, trim_frames, out_frames;
      logic [31:0]       align;
      scan_state_type    state;
      wav_out_beat_type  due_beats [$];
      int                mismatches;
      int                beats_seen;

      function new();
         state = SCAN_HEADER;
         pos = 0;
         data_len = 0;
         skip = 0;
         emit = 0;
         align = 0;
         trim_frames = 0;
         out_frames = 0;
         mismatches = 0;
         beats_seen = 0;
      endfunction

      function void set_reg(logic idx, logic [CFG_W-1:0] v);
         if (idx == REG_TRIM) begin
            trim_frames = v;
         end else begin
            out_frames = v;
         end
      endfunction

      function logic [31:0] le(int at, int n);
         logic [31:0] v;
         int i;
         v = 0;
         for (i = n - 1; i >= 0; i--) v = (v << 8) | hdr[at + i];
         return v;
      endfunction

      function void add_beat(logic [BYTE_W-1:0] d, err_type e, logic dl);
         wav_out_beat_type b;
         b.data = d;
         b.err = e;
         b.run_last = 1'b0;
         b.delivery_last = dl;
         due_beats.push_back(b);
      endfunction

      function err_type header_verdict(logic ended);
         logic [31:0] ch, al;
         longint unsigned rsz, dsz, frames;
         ch = le(22, 2);
         al = le(32, 2);
         rsz = le(4, 4);
         dsz = le(40, 4);
         if (le(0, 4) != TAG_RIFF || le(8, 4) != TAG_WAVE || le(12, 4) != TAG_FMT ||
             le(36, 4) != TAG_DATA || le(16, 4) != FMT_CHUNK_LEN ||
             le(20, 2) != PCM_FORMAT || (ch != 1 && ch != 2) ||
             le(24, 4) != SAMPLE_HZ || le(34, 2) != SAMPLE_BITS || al != ch * 2 ||
             le(28, 4) != SAMPLE_HZ * al || rsz + 8 != HEADER_BYTES + dsz ||
             dsz % al != 0)
            return ERR_CANON;
         if (ended && dsz != 0) return ERR_LENGTH;
         frames = dsz / al;
         if (trim_frames > frames || out_frames > frames - trim_frames) return ERR_AUDIO;
         if (out_frames * al > 64'hFFFF_FFFF - RIFF_OVERHEAD) return ERR_LIMIT;
         align = al;
         data_len = dsz;
         skip = trim_frames * al;
         emit = out_frames * al;
         return ERR_NONE;
      endfunction

      function void take_source_byte(logic [BYTE_W-1:0] b, logic ended);
         int queued;
         int i;
         err_type e;
         logic [31:0] riff_size;
         logic [BYTE_W-1:0] v;
         longint unsigned d;
         queued = due_beats.size();
         case (state)
            SCAN_HEADER: begin
               hdr[pos] = b;
               pos++;
               if (pos < HEADER_BYTES) begin
                  if (ended) begin
                     add_beat(0, ERR_SHORT, 1'b0);
                     pos = 0;
                  end
               end else begin
                  e = header_verdict(ended);
                  if (e != ERR_NONE) begin
                     add_beat(0, e, 1'b0);
                     state = DROP_REST;
                  end else begin
                     riff_size = RIFF_OVERHEAD + emit[31:0];
                     for (i = 0; i < HEADER_BYTES; i++) begin
                        v = hdr[i];
                        if (i >= 4 && i < 8) v = riff_size[8*(i-4) +: 8];
                        else if (i >= 40) v = emit[8*(i-40) +: 8];
                        add_beat(v, ERR_NONE, i == HEADER_BYTES - 1 && emit == 0);
                     end
                     state = PASS_DATA;
                  end
                  if (ended) begin
                     state = SCAN_HEADER;
                     pos = 0;
                  end
               end
            end
            PASS_DATA: begin
               d = pos - HEADER_BYTES;
               if (d >= skip && d - skip < emit) add_beat(b, ERR_NONE, d - skip == emit - 1);
               if (pos < POS_LIMIT) pos++;
               if (ended) begin
                  if (pos != HEADER_BYTES + data_len) add_beat(0, ERR_LENGTH, 1'b0);
                  state = SCAN_HEADER;
                  pos = 0;
               end
            end
            default: begin
               if (ended) begin
                  state = SCAN_HEADER;
                  pos = 0;
               end
            end
         endcase
         if (due_beats.size() > queued) due_beats[due_beats.size() - 1].run_last = 1'b1;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_out_beat(logic [BYTE_W-1:0] data, logic [ERR_W-1:0] err, logic rl, logic dl);
         wav_out_beat_type want;
         beats_seen++;
         if (due_beats.size() == 0) begin
            report($sformatf("beat %0d unexpected: byte %h error %0d", beats_seen, data, err));
            return;
         end
         want = due_beats.pop_front();
         if (data !== want.data)
            report($sformatf("beat %0d out_byte %h, want %h", beats_seen, data, want.data));
         if (err !== want.err)
            report($sformatf("beat %0d error_code %0d, want %0d", beats_seen, err, want.err));
         if (rl !== want.run_last)
            report($sformatf("beat %0d run_last %b, want %b", beats_seen, rl, want.run_last));
         if (dl !== want.delivery_last)
            report($sformatf("beat %0d delivery_last %b, want %b", beats_seen, dl,
                             want.delivery_last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite, pready;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata, prdata;

   pcm_wav_req_if req_bus ();
   pcm_wav_rsp_if rsp_bus ();

   wav_trim_tracker tracker;
   logic [BYTE_W-1:0] wav_bytes [$];
   int idle_pct = 0;
   int stall_pct = 0;
   int beats_sent = 0;
   bit holding = 1'b0;
   logic [CFG_W-1:0] cur_trim, cur_outs;

   pcm16_wav_header_check_and_trim dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !holding && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.take_source_byte(req_bus.in_byte, req_bus.stream_end);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_out_beat(rsp_bus.out_byte, rsp_bus.error_code, rsp_bus.run_last,
                                   rsp_bus.delivery_last);
      end
   end

   initial begin
      #2_000_000;
      $display("pcm16_wav_header_check_and_trim_tb failed");
      $finish;
   end

   task send_beat(logic [BYTE_W-1:0] b, logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.stream_end <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task send_stream();
      int i;
      for (i = 0; i < wav_bytes.size(); i++) send_beat(wav_bytes[i], i == wav_bytes.size() - 1);
      beats_sent += wav_bytes.size();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   function void add_le(logic [31:0] v, int n);
      int i;
      for (i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
   endfunction

   function void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) wav_bytes.push_back(s[i]);
   endfunction

   function void add_noise(int n);
      int i;
      for (i = 0; i < n; i++) wav_bytes.push_back(BYTE_W'($urandom_range(255)));
   endfunction

   function void start_header(int ch, logic [31:0] dsz);
      logic [31:0] al;
      al = 2 * ch;
      wav_bytes.delete();
      add_text("RIFF");
      add_le(dsz + RIFF_OVERHEAD, 4);
      add_text("WAVEfmt ");
      add_le(FMT_CHUNK_LEN, 4);
      add_le(PCM_FORMAT, 2);
      add_le(ch, 2);
      add_le(SAMPLE_HZ, 4);
      add_le(SAMPLE_HZ * al, 4);
      add_le(al, 2);
      add_le(SAMPLE_BITS, 2);
      add_text("data");
      add_le(dsz, 4);
   endfunction

   task send_file(int ch, logic [31:0] dsz, int n);
      start_header(ch, dsz);
      add_noise(n);
      send_stream();
   endtask

   task random_file();
      int kind, ch, frames, n, at;
      logic [31:0] dsz;
      kind = $urandom_range(99);
      ch = $urandom_range(1, 2);
      if ($urandom_range(9) != 0) frames = cur_trim + cur_outs + $urandom_range(3);
      else frames = $urandom_range(4);
      dsz = frames * ch * 2;
      n = ($urandom_range(3) == 0) ? $urandom_range(dsz + 4) : dsz;
      if (kind < 80) begin
         start_header(ch, dsz);
         if (kind >= 65) begin
            // one damaged header byte
            at = $urandom_range(HEADER_BYTES - 1);
            wav_bytes[at] = wav_bytes[at] ^ BYTE_W'($urandom_range(1, 255));
            n = $urandom_range(6);
         end
         add_noise(n);
      end else if (kind < 88) begin
         start_header(ch, dsz);
         at = $urandom_range(HEADER_BYTES - 2);
         wav_bytes = wav_bytes[0:at];
      end else if (kind < 94) begin
         start_header($urandom_range(3), $urandom_range(12));
         add_noise($urandom_range(6));
      end else begin
         wav_bytes.delete();
         add_noise($urandom_range(1, 60));
      end
      send_stream();
   endtask

   task csr_access(logic idx, logic [CFG_W-1:0] v);
      logic [CSR_DW-1:0] got;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'({idx, 2'b00});
      pwdata <= CSR_DW'(v);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      tracker.set_reg(idx, v);
      if (got !== CSR_DW'(v))
         tracker.report($sformatf("register %0d reads %h, wrote %h", idx, got, v));
   endtask

   task settle();
      while (tracker.due_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task configure(logic [CFG_W-1:0] t, logic [CFG_W-1:0] o);
      settle();
      csr_access(REG_TRIM, t);
      csr_access(REG_OUTS, o);
      cur_trim = t;
      cur_outs = o;
   endtask

   task hold_receiver(int n);
      holding = 1'b1;
      repeat (n) @(posedge clock);
      holding = 1'b0;
   endtask

   initial begin
      int p, phase_start;
      tracker = new();
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      req_bus.stream_end = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(0, 0);
      wav_bytes.delete();
      add_noise(1);
      send_stream();
      send_file(1, 0, 0);

      // largest stereo data size the riff field allows, fed only in part
      // output held off while the source keeps pushing
      configure(0, 31'h3FFF_FFF6);
      fork
         hold_receiver(HOLD_CYCLES);
         send_file(2, 32'hFFFF_FFD8, 8);
      join

      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 50;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 50;
            end
            default: begin
               idle_pct = 10;
               stall_pct = 10;
            end
         endcase
         configure($urandom_range(3), $urandom_range(6));
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) random_file();
      end

      idle_pct = 0;
      stall_pct = 0;
      settle();
      if (tracker.mismatches == 0) begin
         $display("pcm16_wav_header_check_and_trim_tb passed");
      end else begin
         $display("pcm16_wav_header_check_and_trim_tb failed");
      end
      $finish;
   end

endmodule

>>> pcm16_wav_header_check_and_trim.f
src/pcm_wav_pkg.sv
src/pcm_wav_if.sv
src/pcm_wav_ram.sv
src/pcm16_wav_header_check_and_trim.sv
tb/pcm16_wav_header_check_and_trim_tb.sv
